// ===== design/dlf_pkg.sv =====
// Shared constants, codes, types and tables of the dense layer block.
package dlf_pkg;

   localparam int VALUE_W    = 16;
   localparam int ACC_W      = 40;
   localparam int PROD_W     = 2 * VALUE_W;
   localparam int MAX_INPUTS = 64;
   localparam int MAX_UNITS  = 16;
   localparam int ROW_W      = $clog2(MAX_INPUTS);
   localparam int UNIT_W     = $clog2(MAX_UNITS);
   localparam int OP_W       = 2;
   localparam int NI_W       = 7;
   localparam int NU_W       = 5;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;
   localparam int FRAC       = 12;

   // exp(-t): t in Q.16, result in Q.30
   localparam int EXP_ARG_W  = 33;
   localparam int EXP_W      = 31;
   localparam int RANGE_W    = 21;
   localparam int K_W        = 6;
   localparam int S_W        = 16;
   localparam int Y_W        = 32;
   localparam int LN2_Q16    = 45426;
   localparam int EXP_LIMIT  = 40 * LN2_Q16;
   localparam int ONE_Q30    = 1 << 30;

   // rounding divider
   localparam int NUM_W      = 43;
   localparam int DEN_W      = 35;
   localparam int REM_W      = 44;
   localparam int QUOT_W     = 13;
   localparam int QSTEP_W    = 4;

   localparam logic [OP_W-1:0] OP_WEIGHT  = 2'd0;
   localparam logic [OP_W-1:0] OP_BIAS    = 2'd1;
   localparam logic [OP_W-1:0] OP_REPLACE = 2'd2;
   localparam logic [OP_W-1:0] OP_SAMPLE  = 2'd3;

   localparam logic [MODE_W-1:0] MODE_IDENTITY = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOGISTIC = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TANH     = 2'd2;
   localparam logic [MODE_W-1:0] MODE_SOFTMAX  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_INPUTS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_UNITS     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANSFER_MODE = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAC,
      ST_MAC_WAIT,
      ST_MAX,
      ST_EXP,
      ST_EXP_WAIT,
      ST_DIV,
      ST_DIV_WAIT,
      ST_OUT
   } ctrl_state_type;

   typedef enum logic [1:0] {
      EXP_IDLE,
      EXP_RANGE,
      EXP_SERIES,
      EXP_SCALE
   } exp_phase_type;

   typedef struct packed {
      logic              capture;
      logic              first;
      logic              mac_issue;
      logic              max_step;
      logic              sum_clear;
      logic              exp_start;
      logic              e_store;
      logic              div_start;
      logic              out_load;
      logic              out_last;
      logic [ROW_W-1:0]  sample_idx;
      logic [UNIT_W-1:0] unit;
      logic [MODE_W-1:0] mode;
   } dlf_cmd_type;

   typedef struct packed {
      logic mac_busy;
      logic exp_done;
      logic div_done;
      logic out_free;
   } dlf_status_type;

   // ln(1 + 2^-(i+1)) in Q.16
   function automatic logic [S_W-1:0] ln_step(input logic [3:0] i);
      logic [S_W-1:0] v;
      case (i)
         4'd0:    v = 16'd26573;
         4'd1:    v = 16'd14624;
         4'd2:    v = 16'd7719;
         4'd3:    v = 16'd3973;
         4'd4:    v = 16'd2017;
         4'd5:    v = 16'd1016;
         4'd6:    v = 16'd510;
         4'd7:    v = 16'd256;
         4'd8:    v = 16'd128;
         4'd9:    v = 16'd64;
         4'd10:   v = 16'd32;
         4'd11:   v = 16'd16;
         4'd12:   v = 16'd8;
         4'd13:   v = 16'd4;
         4'd14:   v = 16'd2;
         default: v = 16'd1;
      endcase
      return v;
   endfunction

endpackage

// ===== design/dlf_exp.sv =====
// Iterative exp(-t) unit: range reduction by ln2, then shift-and-add series.
module dlf_exp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [dlf_pkg::EXP_ARG_W-1:0] exp_arg,
   output logic                          exp_done,
   output logic [dlf_pkg::EXP_W-1:0]     exp_result
);
   import dlf_pkg::*;

   exp_phase_type      phase_ff, phase_in;
   logic [3:0]         step_ff, step_in;
   logic [RANGE_W-1:0] rem_ff, rem_in;
   logic [K_W-1:0]     k_ff, k_in;
   logic [S_W-1:0]     s_ff, s_in;
   logic [Y_W-1:0]     y_ff, y_in;
   logic [EXP_W-1:0]   res_ff, res_in;
   logic               done_ff, done_in;

   logic [RANGE_W:0]   ln2_shift;
   logic [RANGE_W-1:0] rem_next;
   logic [S_W-1:0]     lstep;
   logic [Y_W-1:0]     y_cl;

   always_comb begin
      phase_in  = phase_ff;
      step_in   = step_ff;
      rem_in    = rem_ff;
      k_in      = k_ff;
      s_in      = s_ff;
      y_in      = y_ff;
      res_in    = res_ff;
      done_in   = 1'b0;
      ln2_shift = (RANGE_W+1)'(LN2_Q16) << step_ff;
      rem_next  = rem_ff;
      lstep     = ln_step(step_ff);
      y_cl      = (y_ff > Y_W'(ONE_Q30)) ? Y_W'(ONE_Q30) : y_ff;
      case (phase_ff)
         EXP_IDLE: begin
            if (start) begin
               if (exp_arg >= EXP_ARG_W'(EXP_LIMIT)) begin
                  res_in  = '0;
                  done_in = 1'b1;
               end else begin
                  rem_in   = exp_arg[RANGE_W-1:0];
                  k_in     = '0;
                  step_in  = 4'd5;
                  phase_in = EXP_RANGE;
               end
            end
         end
         EXP_RANGE: begin
            // one bit of t / ln2 per cycle
            if ({1'b0, rem_ff} >= ln2_shift) begin
               rem_next           = rem_ff - ln2_shift[RANGE_W-1:0];
               k_in[step_ff[2:0]] = 1'b1;
            end
            rem_in = rem_next;
            if (step_ff == 4'd0) begin
               s_in     = S_W'(LN2_Q16) - rem_next[S_W-1:0];
               y_in     = Y_W'(ONE_Q30 >> 1);
               phase_in = EXP_SERIES;
            end else begin
               step_in = step_ff - 4'd1;
            end
         end
         EXP_SERIES: begin
            if (s_ff >= lstep) begin
               s_in = s_ff - lstep;
               y_in = y_ff + (y_ff >> ({1'b0, step_ff} + 5'd1));
            end
            if (step_ff == 4'd15) begin
               phase_in = EXP_SCALE;
            end
            step_in = step_ff + 4'd1;
         end
         EXP_SCALE: begin
            res_in   = EXP_W'(y_cl >> k_ff);
            done_in  = 1'b1;
            phase_in = EXP_IDLE;
         end
         default: begin
            phase_in = EXP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= EXP_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      k_ff    <= k_in;
      s_ff    <= s_in;
      y_ff    <= y_in;
      res_ff  <= res_in;
   end

   assign exp_done   = done_ff;
   assign exp_result = res_ff;

endmodule

// ===== design/dlf_div.sv =====
// Restoring divider with round-half-up, one quotient bit per cycle.
module dlf_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [dlf_pkg::NUM_W-1:0]  div_num,
   input  logic [dlf_pkg::DEN_W-1:0]  div_den,
   output logic                       div_done,
   output logic [dlf_pkg::QUOT_W-1:0] div_quot
);
   import dlf_pkg::*;

   localparam int SH_W = DEN_W + QUOT_W;

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [QSTEP_W-1:0] step_ff, step_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [QUOT_W-1:0]  q_ff, q_in;
   logic [SH_W-1:0]    den_shift;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      q_in      = q_ff;
      den_shift = SH_W'(den_ff) << step_ff;
      if (busy_ff) begin
         if (SH_W'(rem_ff) >= den_shift) begin
            rem_in        = rem_ff - den_shift[REM_W-1:0];
            q_in[step_ff] = 1'b1;
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end else if (start) begin
         // add half the divisor for round half up
         rem_in  = REM_W'(div_num) + REM_W'(div_den >> 1);
         den_in  = div_den;
         q_in    = '0;
         step_in = QSTEP_W'(QUOT_W - 1);
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      q_ff    <= q_in;
   end

   assign div_done = done_ff;
   assign div_quot = q_ff;

endmodule

// ===== design/dlf_datapath.sv =====
// Datapath: stores, shared multiply-accumulate, transfer arithmetic, result register.
module dlf_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  dlf_pkg::dlf_cmd_type          cmd,
   output dlf_pkg::dlf_status_type       status,
   input  logic [dlf_pkg::OP_W-1:0]      req_operation,
   input  logic [dlf_pkg::ROW_W-1:0]     req_entry_row,
   input  logic [dlf_pkg::UNIT_W-1:0]    req_entry_col,
   input  logic signed [dlf_pkg::VALUE_W-1:0] req_item_value,
   input  logic                          req_is_missing,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [dlf_pkg::UNIT_W-1:0]    rsp_unit_index,
   output logic signed [dlf_pkg::VALUE_W-1:0] rsp_unit_value,
   output logic                          rsp_last_unit
);
   import dlf_pkg::*;

   localparam int RND_W = ACC_W - FRAC + 1;

   logic signed [VALUE_W-1:0] weight_mem [MAX_INPUTS*MAX_UNITS];
   logic signed [VALUE_W-1:0] repl_mem   [MAX_INPUTS];
   logic signed [VALUE_W-1:0] bias_ff    [MAX_UNITS];
   logic signed [ACC_W-1:0]   acc_ff     [MAX_UNITS];
   logic [EXP_W-1:0]          e_ff       [MAX_UNITS];

   logic signed [VALUE_W-1:0] w_rd_ff;
   logic signed [VALUE_W-1:0] repl_rd_ff;
   logic signed [VALUE_W-1:0] sample_ff;
   logic                      missing_ff;
   logic                      s1_valid_ff, s2_valid_ff;
   logic [UNIT_W-1:0]         s1_unit_ff, s2_unit_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]   max_ff;
   logic [DEN_W-1:0]          sum_ff;
   logic                      rsp_valid_ff;
   logic [UNIT_W-1:0]         rsp_index_ff;
   logic signed [VALUE_W-1:0] rsp_value_ff;
   logic                      rsp_last_ff;

   logic signed [VALUE_W-1:0] mac_v;
   logic signed [PROD_W-1:0]  prod;
   logic [UNIT_W-1:0]         acc_idx;
   logic signed [ACC_W-1:0]   acc_rd;
   logic signed [ACC_W-1:0]   mac_base;
   logic signed [ACC_W:0]     mac_wide;
   logic signed [ACC_W-1:0]   mac_sum;
   logic [ACC_W-1:0]          acc_mag;
   logic [ACC_W:0]            diff;
   logic [EXP_ARG_W-1:0]      exp_arg;
   logic                      exp_done;
   logic [EXP_W-1:0]          exp_res;
   logic [NUM_W-1:0]          div_num;
   logic [DEN_W-1:0]          div_den;
   logic                      div_done;
   logic [QUOT_W-1:0]         quot;
   logic signed [RND_W-1:0]   rnd;
   logic signed [VALUE_W-1:0] ident_val;
   logic signed [VALUE_W-1:0] out_val;

   // stores
   always_ff @(posedge clock) begin
      if (cmd.capture && req_operation == OP_WEIGHT) begin
         weight_mem[{req_entry_row, req_entry_col}] <= req_item_value;
      end
      w_rd_ff <= weight_mem[{cmd.sample_idx, cmd.unit}];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture && req_operation == OP_REPLACE) begin
         repl_mem[req_entry_row] <= req_item_value;
      end
      if (cmd.capture && req_operation == OP_SAMPLE) begin
         repl_rd_ff <= repl_mem[cmd.sample_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture && req_operation == OP_BIAS) begin
         bias_ff[req_entry_col] <= req_item_value;
      end
      if (cmd.capture && req_operation == OP_SAMPLE) begin
         sample_ff  <= req_item_value;
         missing_ff <= req_is_missing;
      end
   end

   // multiply-accumulate pipeline: weight read, product, saturating add
   assign mac_v   = missing_ff ? repl_rd_ff : sample_ff;
   assign prod    = mac_v * w_rd_ff;
   assign acc_idx = s2_valid_ff ? s2_unit_ff : cmd.unit;
   assign acc_rd  = acc_ff[acc_idx];

   always_comb begin
      if (cmd.first) begin
         mac_base = {{(ACC_W-VALUE_W-FRAC){bias_ff[s2_unit_ff][VALUE_W-1]}},
                     bias_ff[s2_unit_ff], {FRAC{1'b0}}};
      end else begin
         mac_base = acc_rd;
      end
      mac_wide = {mac_base[ACC_W-1], mac_base} + (ACC_W+1)'(prod_ff);
      if (mac_wide[ACC_W] != mac_wide[ACC_W-1]) begin
         mac_sum = mac_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         mac_sum = mac_wide[ACC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.mac_issue;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_unit_ff <= cmd.unit;
      s2_unit_ff <= s1_unit_ff;
      prod_ff    <= prod;
      if (s2_valid_ff) begin
         acc_ff[s2_unit_ff] <= mac_sum;
      end
   end

   // transfer arithmetic
   assign acc_mag = acc_rd[ACC_W-1] ? ACC_W'(-acc_rd) : acc_rd;
   assign diff    = {max_ff[ACC_W-1], max_ff} - {acc_rd[ACC_W-1], acc_rd};

   always_comb begin
      case (cmd.mode)
         MODE_TANH:    exp_arg = {acc_mag[ACC_W-1:8], 1'b0};
         MODE_SOFTMAX: exp_arg = {1'b0, diff[ACC_W-1:8]};
         default:      exp_arg = {1'b0, acc_mag[ACC_W-1:8]};
      endcase
   end

   dlf_exp u_exp (
      .clock      (clock),
      .reset      (reset),
      .start      (cmd.exp_start),
      .exp_arg    (exp_arg),
      .exp_done   (exp_done),
      .exp_result (exp_res)
   );

   always_ff @(posedge clock) begin
      if (cmd.max_step && (cmd.unit == '0 || acc_rd > max_ff)) begin
         max_ff <= acc_rd;
      end
      if (cmd.sum_clear) begin
         sum_ff <= '0;
      end else if (cmd.e_store) begin
         sum_ff <= sum_ff + DEN_W'(exp_res);
      end
      if (cmd.e_store) begin
         e_ff[cmd.unit] <= exp_res;
      end
   end

   always_comb begin
      div_den = DEN_W'(Y_W'(ONE_Q30) + Y_W'(exp_res));
      case (cmd.mode)
         MODE_TANH: begin
            div_num = {(EXP_W'(ONE_Q30) - exp_res), {FRAC{1'b0}}};
         end
         MODE_SOFTMAX: begin
            div_num = {e_ff[cmd.unit], {FRAC{1'b0}}};
            div_den = sum_ff;
         end
         default: begin
            div_num = acc_rd[ACC_W-1] ? {exp_res, {FRAC{1'b0}}}
                                      : {1'b1, {(NUM_W-1){1'b0}}};
         end
      endcase
   end

   dlf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .div_num  (div_num),
      .div_den  (div_den),
      .div_done (div_done),
      .div_quot (quot)
   );

   // identity: round half up to Q4.12, then saturate
   always_comb begin
      rnd = {acc_rd[ACC_W-1], acc_rd[ACC_W-1:FRAC]} + RND_W'(acc_rd[FRAC-1]);
      if (rnd > RND_W'(32767)) begin
         ident_val = {1'b0, {(VALUE_W-1){1'b1}}};
      end else if (rnd < -RND_W'(32768)) begin
         ident_val = {1'b1, {(VALUE_W-1){1'b0}}};
      end else begin
         ident_val = rnd[VALUE_W-1:0];
      end
      case (cmd.mode)
         MODE_IDENTITY: out_val = ident_val;
         MODE_TANH:     out_val = acc_rd[ACC_W-1] ? -VALUE_W'(quot) : VALUE_W'(quot);
         default:       out_val = VALUE_W'(quot);
      endcase
   end

   // result register: a result is taken while the next one is worked on
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_index_ff <= cmd.unit;
         rsp_value_ff <= out_val;
         rsp_last_ff  <= cmd.out_last;
      end
   end

   assign status.mac_busy = s1_valid_ff | s2_valid_ff;
   assign status.exp_done = exp_done;
   assign status.div_done = div_done;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_unit_index = rsp_index_ff;
   assign rsp_unit_value = rsp_value_ff;
   assign rsp_last_unit  = rsp_last_ff;

endmodule

// ===== design/dlf_ctrl.sv =====
// Controller: settings registers, sample count and the sequencing state machine.
module dlf_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [dlf_pkg::OP_W-1:0]       req_operation,
   input  logic                           csr_write_en,
   input  logic [dlf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dlf_pkg::CSR_DATA_W-1:0] csr_write_data,
   input  dlf_pkg::dlf_status_type        status,
   output dlf_pkg::dlf_cmd_type           cmd
);
   import dlf_pkg::*;

   ctrl_state_type    state_ff, state_in;
   logic [UNIT_W-1:0] u_ff, u_in;
   logic [ROW_W-1:0]  cnt_ff, cnt_in;
   logic [NI_W-1:0]   num_inputs_ff;
   logic [NU_W-1:0]   num_units_ff;
   logic [MODE_W-1:0] mode_ff;

   logic [NI_W-1:0]   ni;
   logic [NU_W-1:0]   nu;
   logic [UNIT_W-1:0] last_u;
   logic              last_sample;
   logic              at_last_u;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_inputs_ff <= NI_W'(MAX_INPUTS);
         num_units_ff  <= NU_W'(MAX_UNITS);
         mode_ff       <= MODE_IDENTITY;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_NUM_INPUTS:    num_inputs_ff <= csr_write_data[NI_W-1:0];
            CSR_NUM_UNITS:     num_units_ff  <= csr_write_data[NU_W-1:0];
            CSR_TRANSFER_MODE: mode_ff       <= csr_write_data[MODE_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp counts into their legal ranges
   always_comb begin
      if (num_inputs_ff == '0) begin
         ni = NI_W'(1);
      end else if (num_inputs_ff > NI_W'(MAX_INPUTS)) begin
         ni = NI_W'(MAX_INPUTS);
      end else begin
         ni = num_inputs_ff;
      end
      if (num_units_ff == '0) begin
         nu = NU_W'(1);
      end else if (num_units_ff > NU_W'(MAX_UNITS)) begin
         nu = NU_W'(MAX_UNITS);
      end else begin
         nu = num_units_ff;
      end
   end

   assign last_u      = UNIT_W'(nu - NU_W'(1));
   assign at_last_u   = (u_ff == last_u);
   assign last_sample = ((NI_W'(cnt_ff) + NI_W'(1)) >= ni);

   always_comb begin
      state_in = state_ff;
      u_in     = u_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.sample_idx = cnt_ff;
      cmd.unit       = u_ff;
      cmd.mode       = mode_ff;
      cmd.first      = (cnt_ff == '0);
      cmd.out_last   = at_last_u;
      req_ready      = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (req_operation == OP_SAMPLE) begin
                  u_in     = '0;
                  state_in = ST_MAC;
               end
            end
         end
         ST_MAC: begin
            cmd.mac_issue = 1'b1;
            u_in          = u_ff + 1'b1;
            if (u_ff == UNIT_W'(MAX_UNITS - 1)) begin
               state_in = ST_MAC_WAIT;
            end
         end
         ST_MAC_WAIT: begin
            if (!status.mac_busy) begin
               u_in = '0;
               if (last_sample) begin
                  cnt_in = '0;
                  case (mode_ff)
                     MODE_SOFTMAX:  state_in = ST_MAX;
                     MODE_IDENTITY: state_in = ST_OUT;
                     default:       state_in = ST_EXP;
                  endcase
               end else begin
                  cnt_in   = cnt_ff + 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_MAX: begin
            cmd.max_step = 1'b1;
            if (at_last_u) begin
               cmd.sum_clear = 1'b1;
               u_in          = '0;
               state_in      = ST_EXP;
            end else begin
               u_in = u_ff + 1'b1;
            end
         end
         ST_EXP: begin
            cmd.exp_start = 1'b1;
            state_in      = ST_EXP_WAIT;
         end
         ST_EXP_WAIT: begin
            if (status.exp_done) begin
               if (mode_ff == MODE_SOFTMAX) begin
                  // gather every exponent and the sum before dividing
                  cmd.e_store = 1'b1;
                  if (at_last_u) begin
                     u_in     = '0;
                     state_in = ST_DIV;
                  end else begin
                     u_in     = u_ff + 1'b1;
                     state_in = ST_EXP;
                  end
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               if (at_last_u) begin
                  u_in     = '0;
                  state_in = ST_IDLE;
               end else begin
                  u_in = u_ff + 1'b1;
                  case (mode_ff)
                     MODE_IDENTITY: state_in = ST_OUT;
                     MODE_SOFTMAX:  state_in = ST_DIV;
                     default:       state_in = ST_EXP;
                  endcase
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         u_ff     <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         u_ff     <= u_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== design/dense_layer_forward.sv =====
// Dense layer forward evaluation: a write request is stored when it is accepted; a sample
// closes the input while sixteen multiply-accumulates run on the one shared multiplier and
// its pipe drains. After the last sample, identity gives one result per cycle while the
// receiver takes them; logistic and tanh run an exp, a divide and a load per unit in turn;
// softmax runs a max search over the units, an exp per unit, then a divide and load per unit.
// Synchronous reset: 64 inputs, 16 units, identity; sample count zero; stores undefined.
module dense_layer_forward (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [dlf_pkg::OP_W-1:0]       req_operation,
   input  logic [dlf_pkg::ROW_W-1:0]      req_entry_row,
   input  logic [dlf_pkg::UNIT_W-1:0]     req_entry_col,
   input  logic signed [dlf_pkg::VALUE_W-1:0] req_item_value,
   input  logic                           req_is_missing,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [dlf_pkg::UNIT_W-1:0]     rsp_unit_index,
   output logic signed [dlf_pkg::VALUE_W-1:0] rsp_unit_value,
   output logic                           rsp_last_unit,
   input  logic                           csr_write_en,
   input  logic [dlf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dlf_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import dlf_pkg::*;

   dlf_cmd_type    cmd;
   dlf_status_type status;

   dlf_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .status         (status),
      .cmd            (cmd)
   );

   dlf_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_operation  (req_operation),
      .req_entry_row  (req_entry_row),
      .req_entry_col  (req_entry_col),
      .req_item_value (req_item_value),
      .req_is_missing (req_is_missing),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_unit_index (rsp_unit_index),
      .rsp_unit_value (rsp_unit_value),
      .rsp_last_unit  (rsp_last_unit)
   );

endmodule

// ===== bench/tb_dense_layer_forward.sv =====
// Self-checking bench for the dense layer block: directed and random requests against a scoreboard.
module tb_dense_layer_forward;
   timeunit 1ns;
   timeprecision 1ps;
   import dlf_pkg::*;

   localparam int STALL_LIMIT = 20000;
   localparam int SETTLE      = 80;
   localparam int FILL_ROWS   = 6;

   typedef struct packed {
      logic [UNIT_W-1:0]         unit_index;
      logic signed [VALUE_W-1:0] unit_value;
      logic                      last_unit;
   } unit_result_type;

   class layer_scoreboard;
      longint       weights[MAX_INPUTS*MAX_UNITS];
      longint       biases[MAX_UNITS];
      longint       replacements[MAX_INPUTS];
      longint       accs[MAX_UNITS];
      int unsigned  samples_seen;
      int unsigned  inputs_reg, units_reg, mode_reg;
      unit_result_type pending[$];
      int           failures;
      longint unsigned ln_tab[16] = '{26573, 14624, 7719, 3973, 2017, 1016, 510, 256,
                                       128, 64, 32, 16, 8, 4, 2, 1};

      function new();
         samples_seen = 0;
         inputs_reg   = 64;
         units_reg    = 16;
         mode_reg     = MODE_IDENTITY;
         failures     = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_NUM_INPUTS) inputs_reg = data;
         else if (idx == CSR_NUM_UNITS) units_reg = data & 5'h1f;
         else if (idx == CSR_TRANSFER_MODE) mode_reg = data & 2'h3;
      endfunction

      // exp(-t), t in Q.16, result in Q.30
      function longint unsigned exp_neg(longint unsigned t);
         longint unsigned k, s, y;
         k = t / LN2_Q16;
         if (k >= 40) return 0;
         s = LN2_Q16 - (t - k * LN2_Q16);
         y = 64'd1 << 29;
         for (int i = 0; i < 16; i++) begin
            if (s >= ln_tab[i]) begin
               s -= ln_tab[i];
               y += y >> (i + 1);
            end
         end
         if (y > (64'd1 << 30)) y = 64'd1 << 30;
         return y >> k;
      endfunction

      function longint unsigned rdiv(longint unsigned n, longint unsigned d);
         return (n + d / 2) / d;
      endfunction

      function longint clip16(longint v);
         if (v > 32767) return 32767;
         if (v < -32768) return -32768;
         return v;
      endfunction

      function longint acc_add(longint a, longint p);
         longint mx, mn;
         mx = (64'sd1 <<< 39) - 1;
         mn = -mx - 1;
         if (p > 0 && a > mx - p) return mx;
         if (p < 0 && a < mn - p) return mn;
         return a + p;
      endfunction

      function longint unsigned magnitude(longint a);
         longint unsigned m;
         m = a < 0 ? -a : a;
         m >>= 8;
         if (m > (64'd1 << 40)) m = 64'd1 << 40;
         return m;
      endfunction

      function longint squash(longint a);
         longint unsigned e;
         longint r;
         if (mode_reg == MODE_LOGISTIC) begin
            e = exp_neg(magnitude(a));
            if (a >= 0) return rdiv(64'd1 << 42, (64'd1 << 30) + e);
            return rdiv(e << FRAC, (64'd1 << 30) + e);
         end
         if (mode_reg == MODE_TANH) begin
            e = exp_neg(magnitude(a) * 2);
            r = rdiv(((64'd1 << 30) - e) << FRAC, (64'd1 << 30) + e);
            return a < 0 ? -r : r;
         end
         // identity: round half up to Q4.12
         return clip16((a >>> FRAC) + ((a >>> (FRAC - 1)) & 1));
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [ROW_W-1:0] row,
                                 logic [UNIT_W-1:0] col, logic signed [VALUE_W-1:0] val,
                                 logic miss);
         int unsigned ni, nu;
         longint v, mx;
         longint unsigned d, sum;
         longint unsigned e[MAX_UNITS];
         unit_result_type res;
         v = val;
         case (op)
            OP_WEIGHT:  weights[row*MAX_UNITS + col] = v;
            OP_BIAS:    biases[col] = v;
            OP_REPLACE: replacements[row] = v;
            default: begin
               ni = inputs_reg < 1 ? 1 : (inputs_reg > MAX_INPUTS ? MAX_INPUTS : inputs_reg);
               nu = units_reg < 1 ? 1 : (units_reg > MAX_UNITS ? MAX_UNITS : units_reg);
               if (samples_seen == 0)
                  for (int u = 0; u < MAX_UNITS; u++) accs[u] = biases[u] * 4096;
               if (miss) v = replacements[samples_seen];
               for (int u = 0; u < MAX_UNITS; u++)
                  accs[u] = acc_add(accs[u], v * weights[samples_seen*MAX_UNITS + u]);
               samples_seen++;
               if (samples_seen >= ni) begin
                  samples_seen = 0;
                  sum = 0;
                  if (mode_reg == MODE_SOFTMAX) begin
                     mx = accs[0];
                     for (int u = 1; u < nu; u++) if (accs[u] > mx) mx = accs[u];
                     for (int u = 0; u < nu; u++) begin
                        d = (mx - accs[u]) >> 8;
                        if (d > (64'd1 << 40)) d = 64'd1 << 40;
                        e[u] = exp_neg(d);
                        sum += e[u];
                     end
                  end
                  for (int u = 0; u < nu; u++) begin
                     res.unit_index = UNIT_W'(u);
                     if (mode_reg == MODE_SOFTMAX)
                        res.unit_value = VALUE_W'(clip16(rdiv(e[u] << FRAC, sum)));
                     else
                        res.unit_value = VALUE_W'(clip16(squash(accs[u])));
                     res.last_unit = (u + 1 == nu);
                     pending.push_back(res);
                  end
               end
            end
         endcase
      endfunction

      function void check_result(unit_result_type got);
         unit_result_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result, actual %h", $realtime, got);
            failures++;
            return;
         end
         want = pending.pop_front();
         if (got.unit_index !== want.unit_index) begin
            $display("%0t: unit_index expected %0d actual %0d", $realtime,
                     want.unit_index, got.unit_index);
            failures++;
         end
         if (got.unit_value !== want.unit_value) begin
            $display("%0t: unit_value expected %0d actual %0d (unit %0d)", $realtime,
                     want.unit_value, got.unit_value, want.unit_index);
            failures++;
         end
         if (got.last_unit !== want.last_unit) begin
            $display("%0t: last_unit expected %0b actual %0b", $realtime,
                     want.last_unit, got.last_unit);
            failures++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [OP_W-1:0]        req_operation = OP_WEIGHT;
   logic [ROW_W-1:0]       req_entry_row = '0;
   logic [UNIT_W-1:0]      req_entry_col = '0;
   logic signed [VALUE_W-1:0] req_item_value = '0;
   logic                   req_is_missing = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [UNIT_W-1:0]      rsp_unit_index;
   logic signed [VALUE_W-1:0] rsp_unit_value;
   logic                   rsp_last_unit;
   logic                   csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = CSR_NUM_INPUTS;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   layer_scoreboard sb = new();
   int send_idle = 0;
   int recv_idle = 0;
   int stall_cycles = 0;
   int sent = 0;

   dense_layer_forward dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= recv_idle);

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_request(req_operation, req_entry_row, req_entry_col, req_item_value,
                            req_is_missing);
         if (rsp_valid && rsp_ready)
            sb.check_result('{rsp_unit_index, rsp_unit_value, rsp_last_unit});
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
         else stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic send_request(logic [OP_W-1:0] op, logic [ROW_W-1:0] row,
                               logic [UNIT_W-1:0] col, logic signed [VALUE_W-1:0] val,
                               logic miss);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_entry_row  <= row;
      req_entry_col  <= col;
      req_item_value <= val;
      req_is_missing <= miss;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   task automatic send_sample(logic signed [VALUE_W-1:0] val, logic miss);
      send_request(OP_SAMPLE, ROW_W'($urandom), UNIT_W'($urandom), val, miss);
   endtask

   task automatic send_random_write();
      logic [OP_W-1:0] op;
      op = OP_W'($urandom_range(OP_REPLACE));
      send_request(op, ROW_W'($urandom), UNIT_W'($urandom), VALUE_W'($urandom),
                   1'($urandom));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // registers change only once the block has gone quiet
   task automatic configure(int ni, int nu, int mode);
      drain();
      for (int i = 0; i < 3; i++) begin
         csr_write_en   <= 1'b1;
         csr_index      <= CSR_IDX_W'(i);
         csr_write_data <= CSR_DATA_W'((i == 0) ? ni : (i == 1) ? nu : mode);
         sb.set_register(CSR_IDX_W'(i), CSR_DATA_W'((i == 0) ? ni : (i == 1) ? nu : mode));
         @(posedge clock);
      end
      csr_write_en <= 1'b0;
   endtask

   task automatic run_phase(int budget);
      int ni, nu, mode, pick;
      while (budget > 0) begin
         pick = $urandom_range(19);
         ni = (pick == 0) ? FILL_ROWS : (pick == 1) ? 0 : $urandom_range(1, FILL_ROWS - 1);
         nu = $urandom_range(0, 31);
         mode = $urandom_range(MODE_SOFTMAX);
         configure(ni, nu, mode);
         if (ni < 1) ni = 1;
         if (ni > MAX_INPUTS) ni = MAX_INPUTS;
         repeat ($urandom_range(1, 3)) begin
            for (int s = 0; s < ni; s++) begin
               if ($urandom_range(99) < 15) send_random_write();
               send_sample(VALUE_W'($urandom), $urandom_range(99) < 20);
               budget--;
            end
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill the rows in use and every bias so nothing unwritten is ever read
      for (int r = 0; r < FILL_ROWS; r++) begin
         for (int c = 0; c < MAX_UNITS; c++)
            send_request(OP_WEIGHT, ROW_W'(r), UNIT_W'(c), VALUE_W'($urandom), 1'b0);
         send_request(OP_REPLACE, ROW_W'(r), '0, VALUE_W'($urandom), 1'b0);
      end
      for (int c = 0; c < MAX_UNITS; c++)
         send_request(OP_BIAS, '0, UNIT_W'(c), VALUE_W'($urandom), 1'b0);

      // directed: extremes of the values, every transfer, clamped registers
      send_request(OP_WEIGHT, 6'd63, 4'd15, 16'sh7fff, 1'b1);
      send_request(OP_WEIGHT, 6'd0, 4'd0, 16'sh8000, 1'b0);
      send_request(OP_BIAS, 6'd63, 4'd15, 16'sh8000, 1'b1);
      send_request(OP_REPLACE, 6'd0, 4'd15, 16'sh7fff, 1'b0);
      for (int m = MODE_IDENTITY; m <= MODE_SOFTMAX; m++) begin
         configure(1, 16, m);
         send_sample(16'sh7fff, 1'b0);
         send_sample(16'sh8000, 1'b0);
         send_sample(16'sh0000, 1'b1);
      end
      configure(0, 0, MODE_SOFTMAX);
      send_sample(16'sh1000, 1'b0);
      configure(FILL_ROWS, 31, MODE_TANH);
      for (int s = 0; s < FILL_ROWS; s++) send_sample(VALUE_W'($urandom), s[0]);
      configure(2, 1, MODE_LOGISTIC);
      send_sample(16'sh8000, 1'b1);
      send_sample(16'sh7fff, 1'b0);

      send_idle = 24; recv_idle = 61;
      run_phase(90);
      send_idle = 61; recv_idle = 24;
      run_phase(90);
      send_idle = 0;  recv_idle = 0;
      run_phase(90);

      drain();
      if (sb.failures == 0 && sb.pending.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
